/* hw/rtl/dtp_pkg.sv */
// Package for the deadline timer pool: sizes, codes and the result record.
// No dependencies.
`timescale 1ns / 1ps
package dtp_pkg;
  localparam int NumSlots = 16;
  localparam int SlotW = $clog2(NumSlots);
  localparam int CntW = $clog2(NumSlots + 1);
  localparam int MaxFires = 63;
  localparam int FireW = 6;
  localparam int TimeW = 48;
  localparam logic [TimeW-1:0] TimeMax = '1;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop = 2'd1;
  localparam logic [1:0] KindService = 2'd2;

  localparam logic [2:0] ResStarted = 3'd0;
  localparam logic [2:0] ResStopped = 3'd1;
  localparam logic [2:0] ResIgnored = 3'd2;
  localparam logic [2:0] ResFired = 3'd3;
  localparam logic [2:0] ResArm = 3'd4;
  localparam logic [2:0] ResHalt = 3'd5;
  localparam logic [2:0] ResNoSlot = 3'd6;
  localparam logic [2:0] ResBadId = 3'd7;

  typedef struct packed {
    logic [2:0] code;
    logic [7:0] slot;
    logic [TimeW-1:0] delay;
    logic req;
    logic last;
  } result_t;

  // Saturating 48-bit add.
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction
endpackage

/* hw/rtl/deadline_timer_pool.sv */
// Top level of the deadline timer pool: sequencer, slot registers, output stage.
// Depends on dtp_pkg and dtp_scan.
`timescale 1ns / 1ps
// Usage:
// - s_axis carries one command transaction: start, stop or service, with the
//   current time. s_axis_tready is high only while the block is idle.
// - m_axis returns the results; tlast marks the final result of a command.
// - cfg_valid_i/cfg_ready_o write system_ready; write only while idle.
// - Start: one scan over all slots for the earliest deadline (StStartScan),
//   then the result is registered in StStartRes, then the output handshake.
// - Stop: the result is registered on acceptance, then the output handshake.
// - Service: each fire and the final arm/halt take one full scan over all
//   slots through the compare unit in dtp_scan, each followed by the output
//   handshake in StWait.
// - The single output register holds a result until m_axis_tready; the
//   sequencer waits while the receiver stalls.
// - Reset clears the schedule, the free stack count, the slot count, the
//   order counter, hw_running and system_ready.
module deadline_timer_pool import dtp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: now_time[47:0], start_delay[95:48], repeat_period[143:96],
  // stop_id[151:144]
  input  logic [151:0] s_axis_tdata,
  // tuser: kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_code[2:0], slot_id[10:3], arm_delay[58:11], zero fill
  output logic [63:0]  m_axis_tdata,
  // tuser: request_service
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i
);
  typedef enum logic [2:0] {
    StIdle, StStartScan, StStartRes, StSvcScan, StSvcAct, StWait
  } state_e;

  state_e state_q;
  logic ready_q, hw_q;
  logic [NumSlots-1:0] sched_q;
  logic [TimeW-1:0] dl_q [NumSlots];
  logic [TimeW-1:0] per_q [NumSlots];
  logic [15:0] ord_q [NumSlots];
  logic [SlotW-1:0] stk_q [NumSlots];
  logic [CntW-1:0] free_q, used_q;
  logic [15:0] ocnt_q;
  logic [TimeW-1:0] now_q;
  logic [SlotW-1:0] slot_q, idx_q;
  logic [FireW-1:0] fires_q;
  logic first_q, scan_start;
  logic [1:0] kind;
  logic [7:0] sid;
  result_t res_q;
  logic ovalid_q;
  state_e ret_q;
  logic found;
  logic [SlotW-1:0] best;
  logic [TimeW-1:0] best_dl;

  assign kind = s_axis_tuser;
  assign sid = s_axis_tdata[151:144];
  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {5'd0, res_q.delay, res_q.slot, res_q.code};
  assign m_axis_tuser = res_q.req;
  assign m_axis_tlast = res_q.last;

  // Scan restarts at slot 0 when this is high.
  assign scan_start = (state_q != StStartScan && state_q != StSvcScan);

  dtp_scan u_scan (
    .clk_i, .rst_ni,
    .start_i(scan_start),
    .idx_i(idx_q),
    .sched_i(sched_q[idx_q]),
    .dl_i(dl_q[idx_q]),
    .age_i(ocnt_q - ord_q[idx_q]),
    .found_o(found),
    .best_o(best),
    .best_dl_o(best_dl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b0;
      hw_q <= 1'b0;
      sched_q <= '0;
      free_q <= '0;
      used_q <= '0;
      ocnt_q <= '0;
      fires_q <= '0;
      ovalid_q <= 1'b0;
      ret_q <= StIdle;
    end else begin
      if (cfg_valid_i) ready_q <= cfg_data_i;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (s_axis_tvalid && s_axis_tready) begin
            now_q <= s_axis_tdata[47:0];
            fires_q <= '0;
            unique case (kind)
              KindStart: begin
                if (free_q != '0 || used_q != CntW'(NumSlots)) begin
                  // Pop a freed slot first, else take the next unused one.
                  logic [SlotW-1:0] s;
                  logic [TimeW-1:0] d;
                  if (free_q != '0) begin
                    s = stk_q[free_q[SlotW-1:0] - SlotW'(1)];
                    free_q <= free_q - CntW'(1);
                  end else begin
                    s = used_q[SlotW-1:0];
                    used_q <= used_q + CntW'(1);
                  end
                  d = sat_add(s_axis_tdata[47:0], s_axis_tdata[95:48]);
                  slot_q <= s;
                  dl_q[s] <= d;
                  per_q[s] <= s_axis_tdata[143:96];
                  ord_q[s] <= ocnt_q;
                  ocnt_q <= ocnt_q + 16'd1;
                  first_q <= 1'b1;
                  state_q <= StStartScan;
                end else begin
                  res_q <= '{ResNoSlot, 8'd0, '0, 1'b0, 1'b1};
                  ovalid_q <= 1'b1;
                end
              end
              KindStop: begin
                if ({1'b0, sid} >= 9'(used_q)) begin
                  res_q <= '{ResBadId, sid, '0, 1'b0, 1'b1};
                end else if (!sched_q[sid[SlotW-1:0]]) begin
                  res_q <= '{ResIgnored, sid, '0, 1'b0, 1'b1};
                end else begin
                  sched_q[sid[SlotW-1:0]] <= 1'b0;
                  stk_q[free_q[SlotW-1:0]] <= sid[SlotW-1:0];
                  free_q <= free_q + CntW'(1);
                  res_q <= '{ResStopped, sid, '0, 1'b0, 1'b1};
                end
                ovalid_q <= 1'b1;
              end
              KindService: begin
                hw_q <= 1'b0;
                state_q <= StSvcScan;
              end
              default: ;
            endcase
          end
        end
        StStartScan: begin
          // Any other scheduled deadline at or before the new one.
          if (sched_q[idx_q] && dl_q[idx_q] <= dl_q[slot_q]) first_q <= 1'b0;
          idx_q <= idx_q + SlotW'(1);
          if (idx_q == SlotW'(NumSlots - 1)) state_q <= StStartRes;
        end
        StStartRes: begin
          sched_q[slot_q] <= 1'b1;
          res_q <= '{ResStarted, 8'(slot_q), '0,
                     ready_q && (!hw_q || first_q), 1'b1};
          ovalid_q <= 1'b1;
          state_q <= StIdle;
        end
        StSvcScan: begin
          idx_q <= idx_q + SlotW'(1);
          if (idx_q == SlotW'(NumSlots - 1)) state_q <= StSvcAct;
        end
        StSvcAct: begin
          idx_q <= '0;
          if (found && fires_q != FireW'(MaxFires) && now_q >= best_dl) begin
            res_q <= '{ResFired, 8'(best), '0, 1'b0, 1'b0};
            fires_q <= fires_q + FireW'(1);
            if (per_q[best] == '0) begin
              sched_q[best] <= 1'b0;
              stk_q[free_q[SlotW-1:0]] <= best;
              free_q <= free_q + CntW'(1);
            end else begin
              dl_q[best] <= sat_add(best_dl, per_q[best]);
              ord_q[best] <= ocnt_q;
              ocnt_q <= ocnt_q + 16'd1;
            end
            ret_q <= StSvcScan;
          end else if (found) begin
            res_q <= '{ResArm, 8'd0,
                       (best_dl > now_q) ? best_dl - now_q : TimeW'(1), 1'b0, 1'b1};
            hw_q <= 1'b1;
            ret_q <= StIdle;
          end else begin
            res_q <= '{ResHalt, 8'd0, '0, 1'b0, 1'b1};
            ret_q <= StIdle;
          end
          ovalid_q <= 1'b1;
          state_q <= StWait;
        end
        StWait: begin
          // Hold until the receiver takes the result.
          if (m_axis_tready) state_q <= ret_q;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready) else $error("ready while busy");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= used_q) else $error("free stack exceeds used slots");
  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= FireW'(MaxFires)) else $error("fire cap exceeded");
`endif
endmodule

/* hw/rtl/dtp_scan.sv */
// Sequential earliest-slot search: one slot compared per cycle.
// Depends on dtp_pkg.
`timescale 1ns / 1ps
module dtp_scan import dtp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SlotW-1:0] idx_i,
  input  logic             sched_i,
  input  logic [TimeW-1:0] dl_i,
  input  logic [15:0]      age_i,
  output logic             found_o,
  output logic [SlotW-1:0] best_o,
  output logic [TimeW-1:0] best_dl_o
);
  logic [15:0] best_age_q;
  logic better;

  // Deadline first, then older scheduling wins.
  assign better = sched_i && (!found_o || dl_i < best_dl_o ||
                  (dl_i == best_dl_o && age_i > best_age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o <= 1'b0;
    end else if (start_i) begin
      found_o <= 1'b0;
    end else if (better) begin
      found_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!start_i && better) begin
      best_o <= idx_i;
      best_dl_o <= dl_i;
      best_age_q <= age_i;
    end
  end
endmodule

/* tb/tb.sv */
// Self-checking testbench for the deadline timer pool: directed and random command traffic
// is checked against a behavioral scoreboard of the timer slots.
// Depends on dtp_pkg and the deadline_timer_pool RTL.
`timescale 1ns / 1ps
module tb;
  import dtp_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int CycleLimit = 2000000;
  localparam int IdleGuard = 40;  // longer than one full slot scan

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: now_time, start_delay, repeat_period, stop_id (lowest bit up)
  logic [151:0] s_axis_tdata = '0;
  // tuser: kind
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: result_code, slot_id, arm_delay, zero fill (lowest bit up)
  logic [63:0]  m_axis_tdata;
  // tuser: request_service
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;

  always #6 clk_i = ~clk_i;

  deadline_timer_pool uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Scoreboard copy of the timer pool.
  logic [TimeW-1:0] tmr_deadline [NumSlots];
  logic [TimeW-1:0] tmr_period [NumSlots];
  logic [15:0]      tmr_seq [NumSlots];
  logic             tmr_armed [NumSlots];
  logic [SlotW-1:0] freed_slots [NumSlots];
  int               freed_cnt = 0;
  int               slots_taken = 0;
  logic             hw_busy = 1'b0;
  logic [15:0]      seq_cnt = '0;
  logic             sys_ready = 1'b0;

  result_t pending_results [$];
  int      errors = 0;
  int      cycles = 0;
  int      hold_cycles = 0;
  logic    holding = 1'b0;
  logic [TimeW-1:0] clock_ns = '0;

  function automatic logic [TimeW-1:0] add_sat(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = a + b;
    if (sum > {1'b0, TimeMax}) return TimeMax;
    return sum[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  // True when slot a is due ahead of slot b: earlier deadline, then older.
  function automatic bit runs_first(input int a, input int b);
    logic [15:0] age_a, age_b;
    if (tmr_deadline[a] != tmr_deadline[b]) return tmr_deadline[a] < tmr_deadline[b];
    age_a = seq_cnt - tmr_seq[a];
    age_b = seq_cnt - tmr_seq[b];
    return age_a > age_b;
  endfunction

  function automatic int next_due();
    int best;
    best = NumSlots;
    for (int i = 0; i < NumSlots; i++)
      if (tmr_armed[i] && (best == NumSlots || runs_first(i, best))) best = i;
    return best;
  endfunction

  function automatic void free_slot(input int s);
    tmr_armed[s] = 1'b0;
    if (freed_cnt < NumSlots) begin
      freed_slots[freed_cnt] = s[SlotW-1:0];
      freed_cnt++;
    end
  endfunction

  function automatic void push_result(input logic [2:0] code, input int slot,
                                      input logic [TimeW-1:0] dly, input logic req,
                                      input logic last);
    result_t r;
    r.code = code;
    r.slot = slot[7:0];
    r.delay = dly;
    r.req = req;
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out the results of one accepted command and advance the pool.
  function automatic void predict_timer_cmd(input logic [1:0] kind,
                                            input logic [TimeW-1:0] now,
                                            input logic [TimeW-1:0] dly,
                                            input logic [TimeW-1:0] per,
                                            input logic [7:0] sid);
    int s, fires;
    bit earliest;
    case (kind)
      KindStart: begin
        if (freed_cnt > 0) begin
          freed_cnt--;
          s = freed_slots[freed_cnt];
        end else if (slots_taken < NumSlots) begin
          s = slots_taken;
          slots_taken++;
        end else begin
          push_result(ResNoSlot, 0, '0, 1'b0, 1'b1);
          return;
        end
        tmr_deadline[s] = add_sat(now, dly);
        tmr_period[s] = per;
        tmr_seq[s] = seq_cnt;
        seq_cnt++;
        earliest = 1'b1;
        for (int i = 0; i < NumSlots; i++)
          if (tmr_armed[i] && tmr_deadline[i] <= tmr_deadline[s]) earliest = 1'b0;
        tmr_armed[s] = 1'b1;
        push_result(ResStarted, s, '0, sys_ready && (!hw_busy || earliest), 1'b1);
      end
      KindStop: begin
        if (sid >= slots_taken) push_result(ResBadId, sid, '0, 1'b0, 1'b1);
        else if (!tmr_armed[sid]) push_result(ResIgnored, sid, '0, 1'b0, 1'b1);
        else begin
          free_slot(sid);
          push_result(ResStopped, sid, '0, 1'b0, 1'b1);
        end
      end
      KindService: begin
        hw_busy = 1'b0;
        fires = 0;
        while (fires < MaxFires) begin
          s = next_due();
          if (s == NumSlots || now < tmr_deadline[s]) break;
          push_result(ResFired, s, '0, 1'b0, 1'b0);
          fires++;
          if (tmr_period[s] == '0) free_slot(s);
          else begin
            tmr_deadline[s] = add_sat(tmr_deadline[s], tmr_period[s]);
            tmr_seq[s] = seq_cnt;
            seq_cnt++;
          end
        end
        s = next_due();
        if (s == NumSlots) push_result(ResHalt, 0, '0, 1'b0, 1'b1);
        else begin
          hw_busy = 1'b1;
          push_result(ResArm, 0, (tmr_deadline[s] > now) ? tmr_deadline[s] - now : 48'd1,
                      1'b0, 1'b1);
        end
      end
      default: ;  // unused kind: no result, no state change
    endcase
  endfunction

  // Offer one command and hold it until the block takes the transaction.
  task automatic send_cmd(input logic [1:0] kind, input logic [TimeW-1:0] now,
                          input logic [TimeW-1:0] dly, input logic [TimeW-1:0] per,
                          input logic [7:0] sid);
    s_axis_tdata <= {sid, per, dly, now};
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_timer_cmd(kind, now, dly, per, sid);
  endtask

  task automatic pause_sender(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IdleGuard) @(posedge clk_i);
  endtask

  // Write system_ready once the block has gone idle.
  task automatic set_ready(input logic v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sys_ready = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Long receiver hold-off, counted down in cycles here.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      holding <= 1'b1;
    end else begin
      holding <= 1'b0;
    end
  end

  // Receiver: stall on a rotating pattern, or hold off entirely on request.
  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: tdata=%h tuser=%b tlast=%b",
                                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== e.code || m_axis_tdata[10:3] !== e.slot ||
            m_axis_tdata[58:11] !== e.delay || m_axis_tuser !== e.req ||
            m_axis_tlast !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: exp %0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%b/%b",
                     e.code, e.slot, e.delay, e.req, e.last, m_axis_tdata[2:0],
                     m_axis_tdata[10:3], m_axis_tdata[58:11], m_axis_tuser, m_axis_tlast);
        end
      end
    end
    if (holding) begin
      m_axis_tready <= 1'b0;
    end else begin
      case ((cycles / 300) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("deadline_timer_pool: mismatch");
      $finish;
    end
  end

  // Start, stop and service basics, saturation, bad and idle stop ids.
  task automatic test_basic_ops();
    set_ready(1'b1);
    send_cmd(KindService, 48'd0, '0, '0, 8'd0);              // nothing scheduled: halt
    send_cmd(KindStart, 48'd0, 48'd0, 48'd0, 8'd0);
    send_cmd(KindStart, 48'd0, 48'd10, 48'd5, 8'd0);
    send_cmd(KindStart, TimeMax, TimeMax, TimeMax, 8'hff);   // saturated deadline
    send_cmd(KindStop, 48'd0, '0, '0, 8'hff);                // far out of range
    send_cmd(KindStop, 48'd0, '0, '0, 8'd3);                 // first unused slot
    send_cmd(KindService, 48'd20, '0, '0, 8'd0);
    send_cmd(KindStop, 48'd20, '0, '0, 8'd0);                // already fired: ignored
    send_cmd(KindStart, 48'd20, 48'd1, 48'd0, 8'd0);         // reuses freed slot
    send_cmd(KindUnused, rand_time(), rand_time(), rand_time(), 8'h5a);
    send_cmd(KindService, 48'd21, '0, '0, 8'd0);
    send_cmd(KindStop, 48'd21, '0, '0, 8'd1);
    send_cmd(KindStop, 48'd21, '0, '0, 8'd2);
    send_cmd(KindService, 48'd22, '0, '0, 8'd0);
    set_ready(1'b0);
    send_cmd(KindStart, 48'd100, 48'd3, 48'd0, 8'd0);        // no request while not ready
    send_cmd(KindService, TimeMax, '0, '0, 8'd0);
  endtask

  // Fill every slot, overflow once, then fire them all.
  task automatic test_pool_full();
    clock_ns = 48'd1000;
    for (int i = 0; i <= NumSlots; i++)
      send_cmd(KindStart, clock_ns, 48'(i % 4), 48'd0, 8'd0);
    send_cmd(KindService, clock_ns + 48'd10, '0, '0, 8'd0);
  endtask

  // Two fast periodic timers far overdue hit the fire limit.
  task automatic test_fire_cap();
    set_ready(1'b1);
    clock_ns = 48'd5000;
    send_cmd(KindStart, clock_ns, 48'd0, 48'd1, 8'd0);
    send_cmd(KindStart, clock_ns, 48'd0, 48'd1, 8'd0);
    send_cmd(KindService, clock_ns + 48'd1000, '0, '0, 8'd0);
    send_cmd(KindStop, clock_ns, '0, '0, 8'd0);
    send_cmd(KindStop, clock_ns, '0, '0, 8'd1);
    send_cmd(KindService, clock_ns + 48'd1000, '0, '0, 8'd0);
  endtask

  // Hold the receiver off while commands keep coming.
  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    for (int i = 0; i < 8; i++)
      send_cmd(i % 3 == 2 ? KindService : KindStart, clock_ns, 48'($urandom_range(0, 30)),
               48'($urandom_range(0, 9)), 8'($urandom_range(0, 15)));
  endtask

  task automatic test_random_traffic();
    logic [1:0] kind;
    logic [TimeW-1:0] now, dly, per;
    logic [7:0] sid;
    int pick;
    for (int n = 0; n < 210; n++) begin
      if (n % 65 == 64) set_ready(n % 130 == 64 ? 1'b0 : 1'b1);
      pick = $urandom_range(0, 99);
      kind = pick < 40 ? KindStart : pick < 65 ? KindStop : pick < 95 ? KindService
           : KindUnused;
      clock_ns = clock_ns + 48'($urandom_range(0, 40));
      now = ($urandom_range(0, 19) == 0) ? rand_time() : clock_ns;
      dly = ($urandom_range(0, 4) == 0) ? rand_time() : 48'($urandom_range(0, 100));
      pick = $urandom_range(0, 9);
      per = pick < 5 ? '0 : pick < 9 ? 48'($urandom_range(1, 60)) : rand_time();
      sid = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
      send_cmd(kind, now, dly, per, sid);
      // Bursts: long stretches back to back, gaps of random length between them.
      if ($urandom_range(0, 9) < 3) pause_sender($urandom_range(1, 20));
    end
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) tmr_armed[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_pool_full();
    test_fire_cap();
    test_backpressure();
    test_random_traffic();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("deadline_timer_pool: match");
    end else begin
      $display("deadline_timer_pool: mismatch");
    end
    $finish;
  end
endmodule
